FILE: rtl/amb_pkg.sv
// amb_pkg: constants, function codes and sequencer states for the
// adjacency matrix breadth-first search block. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amb_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int ROW_W        = 64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QRD,
        ST_ARD,
        ST_SCAN,
        ST_EMIT,
        ST_BAD
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/adjacency_matrix_bfs.sv
// adjacency_matrix_bfs: breadth-first traversal over a stored adjacency matrix.
// depends on amb_pkg.
// - input channel (i_valid / o_stall): a load beat (func 0) writes one
//   matrix row; loads may follow back to back.
// - a start beat (func 1) runs a traversal; o_stall stays high until the
//   last result beat of that traversal has been placed in the output register.
// - output channel (o_valid / i_stall): one beat per reached vertex, in
//   breadth-first order, last set on the final one; a bad start gives a single
//   beat with bad_start set.
// - each emitted vertex takes one queue read, one row read, a scan by the scan
//   unit that tests one neighbor bit per cycle over n bits, n being the
//   effective vertex count, and a load of the output register.
// - a stalled receiver holds the result in the output register; the sequencer
//   waits in its emit step until the register is free.
// - the config channel (i_cfg_valid / o_cfg_ready) writes vertex_count and is
//   always ready; write it only while the block is idle.
// - reset clears the sequencer, the visited marks, the queue pointers and the
//   output valid flag, and sets vertex_count to 64. the matrix keeps its
//   contents undefined until rows are loaded.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_bfs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [amb_pkg::VIDX_W-1:0]  i_row_index,
    input  wire logic [amb_pkg::ROW_W-1:0]   i_row_bits,
    input  wire logic [amb_pkg::VIDX_W-1:0]  i_start_vertex,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [amb_pkg::VIDX_W-1:0]       o_vertex,
    output logic                             o_last,
    output logic                             o_bad_start,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [amb_pkg::CNT_W-1:0]   i_cfg_data
);

    localparam logic [amb_pkg::CNT_W-1:0] MAXV = amb_pkg::CNT_W'(amb_pkg::MAX_VERTICES);

    amb_pkg::t_state r_state, n_state;

    logic [amb_pkg::CNT_W-1:0]  r_count;
    logic [amb_pkg::ROW_W-1:0]  r_visited, n_visited;
    logic [amb_pkg::CNT_W-1:0]  r_head, n_head;
    logic [amb_pkg::CNT_W-1:0]  r_tail, n_tail;
    logic [amb_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [amb_pkg::VIDX_W-1:0] r_vert, n_vert;

    logic                       r_out_valid, n_out_valid;
    logic [amb_pkg::VIDX_W-1:0] r_out_vertex, n_out_vertex;
    logic                       r_out_last, n_out_last;
    logic                       r_out_bad, n_out_bad;

    logic [amb_pkg::ROW_W-1:0]  r_adj_mem [amb_pkg::MAX_VERTICES];
    logic [amb_pkg::VIDX_W-1:0] r_que_mem [amb_pkg::MAX_VERTICES];
    logic [amb_pkg::ROW_W-1:0]  r_adj_q;
    logic [amb_pkg::VIDX_W-1:0] r_que_q;

    logic [amb_pkg::CNT_W-1:0]  w_n;
    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_bad;
    logic                       w_hit;
    logic                       w_scan_done;

    logic                       w_adj_we;
    logic                       w_adj_re;
    logic                       w_que_we;
    logic                       w_que_re;
    logic [amb_pkg::VIDX_W-1:0] w_que_waddr;
    logic [amb_pkg::VIDX_W-1:0] w_que_wdata;

    assign w_n         = (r_count > MAXV) ? MAXV : r_count;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_bad       = {1'b0, i_start_vertex} >= w_n;
    assign w_hit       = r_adj_q[r_idx[amb_pkg::VIDX_W-1:0]]
                         && !r_visited[r_idx[amb_pkg::VIDX_W-1:0]]
                         && (r_tail < MAXV);
    assign w_scan_done = (r_idx == w_n - 1'b1);

    assign o_stall     = (r_state != amb_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_vertex    = r_out_vertex;
    assign o_last      = r_out_last;
    assign o_bad_start = r_out_bad;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            amb_pkg::ST_IDLE: begin
                if (w_in_acc && i_func == amb_pkg::FUNC_START) begin
                    n_state = w_bad ? amb_pkg::ST_BAD : amb_pkg::ST_QRD;
                end
            end
            amb_pkg::ST_QRD: n_state = amb_pkg::ST_ARD;
            amb_pkg::ST_ARD: n_state = amb_pkg::ST_SCAN;
            amb_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = amb_pkg::ST_EMIT;
                end
            end
            amb_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_head == r_tail) ? amb_pkg::ST_IDLE : amb_pkg::ST_QRD;
                end
            end
            amb_pkg::ST_BAD: begin
                if (w_out_free) begin
                    n_state = amb_pkg::ST_IDLE;
                end
            end
            default: n_state = amb_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_visited    = r_visited;
        n_head       = r_head;
        n_tail       = r_tail;
        n_idx        = r_idx;
        n_vert       = r_vert;
        n_out_vertex = r_out_vertex;
        n_out_last   = r_out_last;
        n_out_bad    = r_out_bad;
        n_out_valid  = r_out_valid && i_stall;
        w_adj_we     = 1'b0;
        w_adj_re     = 1'b0;
        w_que_we     = 1'b0;
        w_que_re     = 1'b0;
        w_que_waddr  = r_tail[amb_pkg::VIDX_W-1:0];
        w_que_wdata  = r_idx[amb_pkg::VIDX_W-1:0];
        case (r_state)
            amb_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_func == amb_pkg::FUNC_LOAD) begin
                        w_adj_we = ({1'b0, i_row_index} < MAXV);
                    end else begin
                        n_visited = '0;
                        n_head    = '0;
                        n_tail    = '0;
                        if (!w_bad) begin
                            w_que_we    = 1'b1;
                            w_que_waddr = '0;
                            w_que_wdata = i_start_vertex;
                            n_tail      = amb_pkg::CNT_W'(1);
                            n_visited[i_start_vertex] = 1'b1;
                        end
                    end
                end
            end
            amb_pkg::ST_QRD: begin
                w_que_re = 1'b1;
            end
            amb_pkg::ST_ARD: begin
                w_adj_re = 1'b1;
                n_vert   = r_que_q;
                n_head   = r_head + 1'b1;
                n_idx    = '0;
            end
            amb_pkg::ST_SCAN: begin
                if (w_hit) begin
                    w_que_we = 1'b1;
                    n_tail   = r_tail + 1'b1;
                    n_visited[r_idx[amb_pkg::VIDX_W-1:0]] = 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end
            amb_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = r_vert;
                    n_out_last   = (r_head == r_tail);
                    n_out_bad    = 1'b0;
                end
            end
            amb_pkg::ST_BAD: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = '0;
                    n_out_last   = 1'b0;
                    n_out_bad    = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amb_pkg::ST_IDLE;
            r_count     <= MAXV;
            r_visited   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_visited   <= n_visited;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_vert       <= n_vert;
        r_out_vertex <= n_out_vertex;
        r_out_last   <= n_out_last;
        r_out_bad    <= n_out_bad;
    end

    // adjacency rows
    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            r_adj_mem[i_row_index] <= i_row_bits;
        end
        if (w_adj_re) begin
            r_adj_q <= r_adj_mem[r_que_q];
        end
    end

    // vertex queue
    always_ff @(posedge i_clk) begin
        if (w_que_we) begin
            r_que_mem[w_que_waddr] <= w_que_wdata;
        end
        if (w_que_re) begin
            r_que_q <= r_que_mem[r_head[amb_pkg::VIDX_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_start) |-> (!o_last && o_vertex == '0))
        else $error("bad start beat carries vertex or last");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amb_pkg::ST_SCAN) |-> (r_head <= r_tail && r_tail <= MAXV))
        else $error("queue pointers out of order during scan");

    a_start_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_func == amb_pkg::FUNC_START && !w_bad)
        |=> (r_tail == amb_pkg::CNT_W'(1) && r_head == '0
             && $countones(r_visited) == 1))
        else $error("traversal not seeded with start vertex");

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amb_pkg::ST_EMIT && r_out_valid && i_stall)
        |=> (r_state == amb_pkg::ST_EMIT))
        else $error("sequencer left emit while output register was full");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// tb: self-checking testbench for adjacency_matrix_bfs, with row loads, directed traversals
// and random phases at several vertex counts, checked beat by beat against a local predictor or typed expected beats.
// depends on amb_pkg and adjacency_matrix_bfs.
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_START,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        logic [amb_pkg::VIDX_W-1:0] vertex;
        logic                       last;
        logic                       bad_start;
    } t_bfs_beat;

    typedef struct packed {
        t_step_kind                 kind;
        logic [amb_pkg::VIDX_W-1:0] idx;
        logic [amb_pkg::ROW_W-1:0]  bits;
        logic [amb_pkg::CNT_W-1:0]  cnt;
        logic                       typed;
        t_bfs_beat                  beat;
    } t_step;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic                         i_func = amb_pkg::FUNC_LOAD;
    logic [amb_pkg::VIDX_W-1:0]   i_row_index = '0;
    logic [amb_pkg::ROW_W-1:0]    i_row_bits = '0;
    logic [amb_pkg::VIDX_W-1:0]   i_start_vertex = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [amb_pkg::VIDX_W-1:0]   o_vertex;
    logic                         o_last;
    logic                         o_bad_start;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [amb_pkg::CNT_W-1:0]    i_cfg_data = '0;

    logic [amb_pkg::ROW_W-1:0]    model_rows [amb_pkg::MAX_VERTICES];
    logic [amb_pkg::CNT_W-1:0]    model_count = 7'd64;
    t_bfs_beat                    pending_beats [$];
    bit                           calm = 1'b0;
    bit                           failed = 1'b0;
    int                           stall_hold = 0;

    t_step directed_plan [0:21] = '{
        '{STEP_START, 6'd0,  64'd0,                  7'd0,   1'b1, '{6'd0,  1'b1, 1'b0}},
        '{STEP_START, 6'd63, 64'd0,                  7'd0,   1'b1, '{6'd63, 1'b1, 1'b0}},
        '{STEP_LOAD,  6'd0,  {64{1'b1}},             7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd0,  64'd0,                  7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_LOAD,  6'd5,  64'h8000_0000_0000_0020, 7'd0,  1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd5,  64'd0,                  7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_CFG,   6'd0,  64'd0,                  7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd0,  64'd0,                  7'd0,   1'b1, '{6'd0,  1'b0, 1'b1}},
        '{STEP_LOAD,  6'd1,  {64{1'b1}},             7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_CFG,   6'd0,  64'd0,                  7'd1,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd0,  64'd0,                  7'd0,   1'b1, '{6'd0,  1'b1, 1'b0}},
        '{STEP_START, 6'd1,  64'd0,                  7'd0,   1'b1, '{6'd0,  1'b0, 1'b1}},
        '{STEP_START, 6'd63, 64'd0,                  7'd0,   1'b1, '{6'd0,  1'b0, 1'b1}},
        '{STEP_CFG,   6'd0,  64'd0,                  7'd127, 1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd1,  64'd0,                  7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd63, 64'd0,                  7'd0,   1'b1, '{6'd63, 1'b1, 1'b0}},
        '{STEP_CFG,   6'd0,  64'd0,                  7'd2,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd1,  64'd0,                  7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd2,  64'd0,                  7'd0,   1'b1, '{6'd0,  1'b0, 1'b1}},
        '{STEP_CFG,   6'd0,  64'd0,                  7'd64,  1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_LOAD,  6'd62, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0,  1'b0, '{6'd0,  1'b0, 1'b0}},
        '{STEP_START, 6'd62, 64'd0,                  7'd0,   1'b0, '{6'd0,  1'b0, 1'b0}}
    };

    adjacency_matrix_bfs DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_row_index    (i_row_index),
        .i_row_bits     (i_row_bits),
        .i_start_vertex (i_start_vertex),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_vertex       (o_vertex),
        .o_last         (o_last),
        .o_bad_start    (o_bad_start),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int active_count();
        return (model_count > amb_pkg::MAX_VERTICES) ? amb_pkg::MAX_VERTICES
                                                     : int'(model_count);
    endfunction

    // breadth-first order of one traversal, or the row store update of a load
    function automatic void bfs_predict(logic func, logic [amb_pkg::VIDX_W-1:0] row,
                                        logic [amb_pkg::ROW_W-1:0] bits,
                                        logic [amb_pkg::VIDX_W-1:0] start);
        int                         n;
        int                         head;
        int                         tail;
        logic [amb_pkg::ROW_W-1:0]  seen;
        logic [amb_pkg::ROW_W-1:0]  edges;
        logic [amb_pkg::VIDX_W-1:0] order [amb_pkg::MAX_VERTICES];
        logic [amb_pkg::VIDX_W-1:0] v;
        t_bfs_beat                  b;
        n = active_count();
        if (func == amb_pkg::FUNC_LOAD) begin
            model_rows[row] = bits;
            return;
        end
        if (int'(start) >= n) begin
            b = '{vertex: '0, last: 1'b0, bad_start: 1'b1};
            pending_beats.push_back(b);
            return;
        end
        seen = '0;
        order[0] = start;
        seen[start] = 1'b1;
        head = 0;
        tail = 1;
        while (head < tail) begin
            v = order[head];
            head++;
            edges = model_rows[v];
            for (int i = 0; i < n; i++) begin
                if (edges[i] && !seen[i] && tail < amb_pkg::MAX_VERTICES) begin
                    order[tail] = amb_pkg::VIDX_W'(i);
                    tail++;
                    seen[i] = 1'b1;
                end
            end
            b = '{vertex: v, last: (head == tail), bad_start: 1'b0};
            pending_beats.push_back(b);
        end
    endfunction

    function automatic logic [amb_pkg::ROW_W-1:0] random_row();
        logic [amb_pkg::ROW_W-1:0] a;
        logic [amb_pkg::ROW_W-1:0] b;
        logic [amb_pkg::ROW_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return a;
            3: return a & b;
            4: return a & b & c;
            default: return amb_pkg::ROW_W'(1) << $urandom_range(0, amb_pkg::ROW_W - 1);
        endcase
    endfunction

    task automatic send_item(logic func, logic [amb_pkg::VIDX_W-1:0] row,
                             logic [amb_pkg::ROW_W-1:0] bits,
                             logic [amb_pkg::VIDX_W-1:0] start, bit use_model);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= func;
        i_row_index    <= row;
        i_row_bits     <= bits;
        i_start_vertex <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (use_model) bfs_predict(func, row, bits, start);
    endtask

    task automatic write_count(logic [amb_pkg::CNT_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_count = value;
    endtask

    task automatic run_step(t_step s);
        case (s.kind)
            STEP_CFG: begin
                write_count(s.cnt);
            end
            STEP_LOAD: begin
                send_item(amb_pkg::FUNC_LOAD, s.idx, s.bits, amb_pkg::VIDX_W'($urandom),
                          1'b1);
            end
            default: begin
                send_item(amb_pkg::FUNC_START, amb_pkg::VIDX_W'($urandom),
                          {$urandom, $urandom}, s.idx, !s.typed);
                if (s.typed) pending_beats.push_back(s.beat);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_bfs_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, actual vertex %0d last %0b bad_start %0b",
                         $time, o_vertex, o_last, o_bad_start);
                failed = 1'b1;
            end else begin
                want = pending_beats.pop_front();
                if ({o_vertex, o_last, o_bad_start} !== want) begin
                    $display("%0t: mismatch, expected vertex %0d last %0b bad_start %0b,",
                             $time, want.vertex, want.last, want.bad_start,
                             " actual vertex %0d last %0b bad_start %0b",
                             o_vertex, o_last, o_bad_start);
                    failed = 1'b1;
                end
            end
        end
        // receiver stall bursts
        if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_hold != 0) begin
            stall_hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall    <= 1'b1;
            stall_hold = $urandom_range(0, 16);
        end else begin
            i_stall    <= 1'b0;
            stall_hold = $urandom_range(0, 30);
        end
    end

    initial begin
        int phase_counts [6];
        int n;
        logic [amb_pkg::VIDX_W-1:0] row;
        logic [amb_pkg::VIDX_W-1:0] start;
        phase_counts = '{$urandom_range(1, 16), 64, $urandom_range(65, 127), 1,
                         $urandom_range(2, 63), 64};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every row gets written once so no traversal reads an unloaded row
        for (int r = 0; r < amb_pkg::MAX_VERTICES; r++)
            send_item(amb_pkg::FUNC_LOAD, amb_pkg::VIDX_W'(r), '0,
                      amb_pkg::VIDX_W'($urandom), 1'b1);

        foreach (directed_plan[k])
            run_step(directed_plan[k]);

        for (int p = 0; p < 6; p++) begin
            write_count(amb_pkg::CNT_W'(phase_counts[p]));
            calm = (p == 5);
            n = active_count();
            for (int k = 0; k < 17; k++) begin
                if ($urandom_range(0, 99) < 55) begin
                    if (n > 0 && $urandom_range(0, 1) == 0) begin
                        row = amb_pkg::VIDX_W'($urandom_range(0, n - 1));
                    end else begin
                        row = amb_pkg::VIDX_W'($urandom);
                    end
                    send_item(amb_pkg::FUNC_LOAD, row, random_row(),
                              amb_pkg::VIDX_W'($urandom), 1'b1);
                end else begin
                    if (n > 0 && $urandom_range(0, 99) < 85) begin
                        start = amb_pkg::VIDX_W'($urandom_range(0, n - 1));
                    end else begin
                        start = amb_pkg::VIDX_W'($urandom);
                    end
                    send_item(amb_pkg::FUNC_START, amb_pkg::VIDX_W'($urandom),
                              {$urandom, $urandom}, start, 1'b1);
                end
            end
        end

        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
